/* rtl/core/mrf_gibbs_indicator_update_defines.svh */
// assertion macros used by the checker of this block
`ifndef MRF_GIBBS_INDICATOR_UPDATE_DEFINES_SVH
`define MRF_GIBBS_INDICATOR_UPDATE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define MGIU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define MGIU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mgiu_pkg.sv */
package mgiu_pkg;

	localparam int MAX_INDICATORS_DEF = 256;

	localparam int KIND_W     = 2;
	localparam int ROW_W      = 8;
	localparam int COL_W      = 8;
	localparam int VALUE_W    = 32;
	localparam int DRAW_W     = 16;
	localparam int PROB_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [30:0] PRIOR_SCALE_RST   = 31'd65536;
	localparam logic [30:0] SLAB_RATIO_RST    = 31'd655360;
	localparam logic [31:0] GRAPH_WEIGHT_RST  = 32'd65536;
	localparam logic [8:0]  ACTIVE_COUNT_RST  = 9'd256;

	localparam logic signed [33:0] LN2_Q16    = 34'sd45426;
	localparam logic signed [34:0] L_LIMIT    = 35'sd2097152;
	localparam logic [16:0]        PROB_ONE   = 17'd65536;
	localparam logic [24:0]        R_MAX      = 25'h100_0000;
	localparam logic [63:0]        F_SAT_QUO  = 64'd2147549184;
	localparam logic signed [32:0] F_FLOOR    = -33'sd2147483648;
	localparam logic signed [32:0] F_ONE      = 33'sd65536;

	localparam logic [3:0] EXP_TERMS     = 4'd12;
	localparam logic [4:0] LN_SQUARINGS  = 5'd16;
	localparam logic [4:0] EXP_SQUARINGS = 5'd6;
	localparam logic [4:0] NORM_TOP      = 5'd30;

	localparam logic [6:0] R_DIV_BITS = 7'd48;
	localparam logic [6:0] F_DIV_BITS = 7'd49;
	localparam logic [6:0] T_DIV_BITS = 7'd32;
	localparam logic [6:0] P_DIV_BITS = 7'd49;

	typedef enum logic [1:0] {
		KIND_MATRIX = 2'd0,
		KIND_BIT    = 2'd1,
		KIND_UPDATE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_SPARSITY = 3'd0,
		CFG_SCALE    = 3'd1,
		CFG_SLAB     = 3'd2,
		CFG_WEIGHT   = 3'd3,
		CFG_ACTIVE   = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_GSTART,
		S_GRUN,
		S_GDRAIN,
		S_GMUL,
		S_GSAT,
		S_LNORM,
		S_LSQ_MUL,
		S_LSQ_ACC,
		S_LN_MUL,
		S_LN_ACC,
		S_RSQ_MUL,
		S_RSQ_USE,
		S_CB_MUL,
		S_CB_USE,
		S_HF_MUL,
		S_HF_USE,
		S_SUM,
		S_CLAMP,
		S_EXP_MUL,
		S_EXP_SET,
		S_ECLAMP,
		S_ESQ_MUL,
		S_ESQ_USE,
		S_PSET,
		S_DIV,
		S_DPOST,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		DOP_R,
		DOP_F,
		DOP_T,
		DOP_P
	} div_op_t;

endpackage

/* rtl/core/mgiu_if.sv */
interface mgiu_in_if;
	import mgiu_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ROW_W-1:0]    row_index;
	logic [COL_W-1:0]    col_index;
	logic [VALUE_W-1:0]  value;
	logic                bit_value;
	logic [DRAW_W-1:0]   uniform_draw;

	modport source (output valid, kind, row_index, col_index, value, bit_value, uniform_draw,
		input ready);
	modport sink (input valid, kind, row_index, col_index, value, bit_value, uniform_draw,
		output ready);
endinterface

interface mgiu_out_if;
	import mgiu_pkg::*;
	logic              valid;
	logic              ready;
	logic              new_indicator;
	logic [PROB_W-1:0] probability;

	modport source (output valid, new_indicator, probability, input ready);
	modport sink (input valid, new_indicator, probability, output ready);
endinterface

interface mgiu_cfg_if;
	import mgiu_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/mrf_gibbs_indicator_update.sv */
// channel | dir | payload                                              | transfer
// cfg     | in  | index, data                                          | valid & ready
// req     | in  | kind, row_index, col_index, value, bit_value, draw   | valid & ready
// rsp     | out | new_indicator, probability                           | valid & ready
//
// req.ready stays high for matrix and bit loads
// an update walks the row/column of the active indicators (n, the active count capped at
// MAX_INDICATORS) on the dual-read matrix memory, then the shared 34x34 multiplier and the
// one-bit-per-cycle divider (twelve series terms) do the rest; normalizing the slab ratio
// for the log loops until its top bit is set
// reset restores config defaults and clears indicator bits and control; the matrix memory is not cleared
// the result register holds while rsp stalls; the next request is taken meanwhile
module mrf_gibbs_indicator_update #(
	parameter int MAX_INDICATORS = mgiu_pkg::MAX_INDICATORS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mgiu_cfg_if.sink   cfg,
	mgiu_in_if.sink    req,
	mgiu_out_if.source rsp
);
	import mgiu_pkg::*;

	localparam int IW    = (MAX_INDICATORS > 1) ? $clog2(MAX_INDICATORS) : 1;
	localparam int NW    = $clog2(MAX_INDICATORS + 1);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int ACC_W = IW + 35;

	typedef enum logic [1:0] {TAG_NONE, TAG_DIAG, TAG_PAIR} rd_tag_t;

	function automatic logic signed [31:0] sat_q16(input logic signed [67:0] p);
		logic hi_zero;
		logic hi_one;
		hi_zero = (p[67:47] == '0);
		hi_one  = (p[67:47] == '1);
		if (hi_zero || hi_one)
			return $signed(p[47:16]);
		else if (p[67])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	// configuration
	logic signed [31:0] sparsity_q;
	logic [30:0]        scale_q;
	logic [30:0]        slab_q;
	logic signed [31:0] weight_q;
	logic [8:0]         active_q;

	// control
	state_t  state_q, state_d;
	div_op_t dop_q;
	rd_tag_t rd_tag_s1, rd_tag_d;
	logic    rsp_valid_q;
	logic [MAX_INDICATORS-1:0] ind_q;

	// payload
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        i_q;
	logic [NW-1:0]        n_q;
	logic signed [31:0]   beta_q;
	logic [15:0]          draw_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]   gterm_q;
	logic [30:0]          m_q;
	logic [4:0]           e_q;
	logic [15:0]          frac_q;
	logic [4:0]           lcnt_q;
	logic signed [31:0]   lnterm_q;
	logic [24:0]          r_q;
	logic [31:0]          h_q;
	logic signed [32:0]   f_q;
	logic signed [31:0]   qterm_q;
	logic signed [34:0]   lsum_q;
	logic                 lneg_q;
	logic [31:0]          t_q;
	logic [32:0]          term_q;
	logic signed [35:0]   sum_q;
	logic [3:0]           ek_q;
	logic [31:0]          ex_q;
	logic [16:0]          p_q;
	logic [64:0]          rem_q;
	logic [63:0]          num_q;
	logic [63:0]          den_q;
	logic [63:0]          quo_q;
	logic [6:0]           dcnt_q;
	logic signed [67:0]   prod_q;
	logic                 rsp_bit_q;
	logic [16:0]          rsp_p_q;

	// graph matrix memory
	logic [31:0] gmem [DEPTH];
	logic [31:0] rda_s1;
	logic [31:0] rdb_s1;
	logic [AW-1:0] raddr_a, raddr_b, waddr;
	logic          mem_we;

	// decode
	logic          acc_in;
	logic          row_ok;
	logic          col_ok;
	logic [IW-1:0] row_ix;
	logic [IW-1:0] col_ix;
	logic          req_ready;
	logic          out_free;
	logic          grun_last;
	logic [30:0]   tau;
	logic [30:0]   cb;
	logic [31:0]   babs;
	logic signed [31:0] acc_sat;
	logic          acc_fits;
	logic signed [5:0]  em16;
	logic signed [21:0] lg;
	logic signed [33:0] mul_a, mul_b;
	logic [64:0]   rem_sh;
	logic          qbit;
	logic signed [34:0] lclamp;
	logic [21:0]   xabs;
	logic [32:0]   denom;
	logic [48:0]   pnum;
	logic [16:0]   p_new;

	assign acc_in    = req.valid && req_ready;
	assign row_ok    = 32'(req.row_index) < MAX_INDICATORS;
	assign col_ok    = 32'(req.col_index) < MAX_INDICATORS;
	assign row_ix    = IW'(req.row_index);
	assign col_ix    = IW'(req.col_index);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign grun_last = (NW'(i_q) + NW'(1)) == n_q;
	assign tau       = (scale_q == '0) ? 31'd1 : scale_q;
	assign cb        = (slab_q == '0) ? 31'd1 : slab_q;
	assign babs      = beta_q[31] ? 32'(-beta_q) : 32'(beta_q);

	assign acc_fits = (acc_q[ACC_W-1:31] == '0) || (acc_q[ACC_W-1:31] == '1);
	assign acc_sat  = acc_fits ? $signed(acc_q[31:0])
		: (acc_q[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	assign em16 = $signed({1'b0, e_q}) - 6'sd16;
	assign lg   = {em16, frac_q};

	assign rem_sh = {rem_q[63:0], num_q[63]};
	assign qbit   = rem_sh >= {1'b0, den_q};

	assign lclamp = (lsum_q > L_LIMIT) ? L_LIMIT
		: ((lsum_q < -L_LIMIT) ? -L_LIMIT : lsum_q);
	assign xabs   = lclamp[34] ? 22'(-lclamp) : 22'(lclamp);

	assign denom = {1'b1, ex_q};
	// round to nearest: add half the divisor
	assign pnum  = lneg_q ? ({1'b0, ex_q, 16'd0} + 49'(denom[32:1]))
		: ({1'b1, 48'd0} + 49'(denom[32:1]));
	assign p_new = (quo_q > 64'(PROB_ONE)) ? PROB_ONE : quo_q[16:0];

	assign cfg.ready         = 1'b1;
	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.new_indicator = rsp_bit_q;
	assign rsp.probability   = rsp_p_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_in && kind_t'(req.kind) == KIND_UPDATE && row_ok)
					state_d = S_GSTART;
			end
			S_GSTART:  state_d = (n_q == '0) ? S_GDRAIN : S_GRUN;
			S_GRUN:    state_d = grun_last ? S_GDRAIN : S_GRUN;
			S_GDRAIN:  state_d = S_GMUL;
			S_GMUL:    state_d = S_GSAT;
			S_GSAT:    state_d = S_LNORM;
			S_LNORM:   state_d = m_q[30] ? S_LSQ_MUL : S_LNORM;
			S_LSQ_MUL: state_d = S_LSQ_ACC;
			S_LSQ_ACC: state_d = (lcnt_q == 5'd1) ? S_LN_MUL : S_LSQ_MUL;
			S_LN_MUL:  state_d = S_LN_ACC;
			S_LN_ACC:  state_d = S_DIV;
			S_RSQ_MUL: state_d = S_RSQ_USE;
			S_RSQ_USE: state_d = S_CB_MUL;
			S_CB_MUL:  state_d = S_CB_USE;
			S_CB_USE:  state_d = S_DIV;
			S_HF_MUL:  state_d = S_HF_USE;
			S_HF_USE:  state_d = S_SUM;
			S_SUM:     state_d = S_CLAMP;
			S_CLAMP:   state_d = S_EXP_MUL;
			S_EXP_MUL: state_d = S_EXP_SET;
			S_EXP_SET: state_d = S_DIV;
			S_ECLAMP:  state_d = S_ESQ_MUL;
			S_ESQ_MUL: state_d = S_ESQ_USE;
			S_ESQ_USE: state_d = (lcnt_q == 5'd1) ? S_PSET : S_ESQ_MUL;
			S_PSET:    state_d = S_DIV;
			S_DIV:     state_d = (dcnt_q == 7'd1) ? S_DPOST : S_DIV;
			S_DPOST: begin
				case (dop_q)
					DOP_R:   state_d = S_RSQ_MUL;
					DOP_F:   state_d = S_HF_MUL;
					DOP_T:   state_d = (ek_q == EXP_TERMS) ? S_ECLAMP : S_EXP_MUL;
					DOP_P:   state_d = S_OUT;
					default: state_d = S_IDLE;
				endcase
			end
			S_OUT:     state_d = out_free ? S_IDLE : S_OUT;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, memory ports, multiplier operands
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		waddr     = {row_ix, col_ix};
		raddr_a   = {k_q, k_q};
		raddr_b   = {k_q, i_q};
		rd_tag_d  = TAG_NONE;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				mem_we    = req.valid && kind_t'(req.kind) == KIND_MATRIX && row_ok && col_ok;
			end
			S_GSTART: rd_tag_d = TAG_DIAG;
			S_GRUN: begin
				raddr_a  = {i_q, k_q};
				raddr_b  = {k_q, i_q};
				rd_tag_d = (i_q != k_q && ind_q[i_q]) ? TAG_PAIR : TAG_NONE;
			end
			S_GMUL: begin
				mul_a = 34'(acc_sat);
				mul_b = 34'(weight_q);
			end
			S_LSQ_MUL: begin
				mul_a = {3'd0, m_q};
				mul_b = {3'd0, m_q};
			end
			S_LN_MUL: begin
				mul_a = 34'(lg);
				mul_b = LN2_Q16;
			end
			S_RSQ_MUL: begin
				mul_a = {9'd0, r_q};
				mul_b = {9'd0, r_q};
			end
			S_CB_MUL: begin
				mul_a = {3'd0, cb};
				mul_b = {3'd0, cb};
			end
			S_HF_MUL: begin
				mul_a = {2'd0, h_q};
				mul_b = 34'(f_q);
			end
			S_EXP_MUL: begin
				mul_a = {1'b0, term_q};
				mul_b = {2'd0, t_q};
			end
			S_ESQ_MUL: begin
				mul_a = {2'd0, ex_q};
				mul_b = {2'd0, ex_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dop_q       <= DOP_R;
			rd_tag_s1   <= TAG_NONE;
			rsp_valid_q <= 1'b0;
			ind_q       <= '0;
			sparsity_q  <= '0;
			scale_q     <= PRIOR_SCALE_RST;
			slab_q      <= SLAB_RATIO_RST;
			weight_q    <= $signed(GRAPH_WEIGHT_RST);
			active_q    <= ACTIVE_COUNT_RST;
		end else begin
			state_q   <= state_d;
			rd_tag_s1 <= rd_tag_d;
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_SPARSITY: sparsity_q <= $signed(cfg.data);
					CFG_SCALE:    scale_q    <= cfg.data[30:0];
					CFG_SLAB:     slab_q     <= cfg.data[30:0];
					CFG_WEIGHT:   weight_q   <= $signed(cfg.data);
					CFG_ACTIVE:   active_q   <= cfg.data[8:0];
					default: ;
				endcase
			end
			if (state_q == S_IDLE && acc_in && kind_t'(req.kind) == KIND_BIT && row_ok)
				ind_q[row_ix] <= req.bit_value;
			case (state_q)
				S_LN_ACC: dop_q <= DOP_R;
				S_CB_USE: dop_q <= DOP_F;
				S_EXP_SET: dop_q <= DOP_T;
				S_PSET:   dop_q <= DOP_P;
				default: ;
			endcase
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
				ind_q[k_q]  <= {1'b0, draw_q} < p_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			gmem[waddr] <= req.value;
		rda_s1 <= gmem[raddr_a];
		rdb_s1 <= gmem[raddr_b];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		case (rd_tag_s1)
			TAG_DIAG: acc_q <= ACC_W'($signed(rda_s1));
			TAG_PAIR: acc_q <= acc_q + ACC_W'($signed(rda_s1)) + ACC_W'($signed(rdb_s1));
			default: ;
		endcase

		case (state_q)
			S_IDLE: begin
				k_q    <= row_ix;
				beta_q <= $signed(req.value);
				draw_q <= req.uniform_draw;
				n_q    <= (32'(active_q) > MAX_INDICATORS) ? NW'(MAX_INDICATORS) : NW'(active_q);
				i_q    <= '0;
			end
			S_GRUN: i_q <= i_q + IW'(1);
			S_GSAT: begin
				gterm_q <= sat_q16(prod_q);
				m_q     <= cb;
				e_q     <= NORM_TOP;
				frac_q  <= '0;
				lcnt_q  <= LN_SQUARINGS;
			end
			S_LNORM: begin
				if (!m_q[30]) begin
					m_q <= {m_q[29:0], 1'b0};
					e_q <= e_q - 5'd1;
				end
			end
			S_LSQ_ACC: begin
				// square keeps 1 <= m < 2; overflow past 2 yields the next log bit
				if (prod_q[61]) begin
					m_q    <= prod_q[61:31];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= prod_q[60:30];
					frac_q <= {frac_q[14:0], 1'b0};
				end
				lcnt_q <= lcnt_q - 5'd1;
			end
			S_LN_ACC: begin
				lnterm_q <= -$signed(prod_q[47:16]);
				rem_q    <= '0;
				quo_q    <= '0;
				num_q    <= {babs, 32'd0};
				den_q    <= 64'(tau);
				dcnt_q   <= R_DIV_BITS;
			end
			S_RSQ_USE: h_q <= prod_q[48:17];
			S_CB_USE: begin
				rem_q  <= '0;
				quo_q  <= '0;
				num_q  <= {1'b1, 63'd0};
				den_q  <= 64'(prod_q[61:0]);
				dcnt_q <= F_DIV_BITS;
			end
			S_HF_USE: qterm_q <= sat_q16(prod_q);
			S_SUM: begin
				lsum_q <= 35'(sparsity_q) + 35'(gterm_q) + 35'(lnterm_q) + 35'(qterm_q);
			end
			S_CLAMP: begin
				lneg_q <= lclamp[34];
				t_q    <= {xabs, 10'd0};
				term_q <= {1'b1, 32'd0};
				sum_q  <= 36'sh1_0000_0000;
				ek_q   <= 4'd1;
			end
			S_EXP_SET: begin
				rem_q  <= '0;
				quo_q  <= '0;
				num_q  <= {prod_q[63:32], 32'd0};
				den_q  <= 64'(ek_q);
				dcnt_q <= T_DIV_BITS;
			end
			S_ECLAMP: begin
				if (sum_q[35])
					ex_q <= '0;
				else if (sum_q[34:32] != '0)
					ex_q <= 32'hffff_ffff;
				else
					ex_q <= sum_q[31:0];
				lcnt_q <= EXP_SQUARINGS;
			end
			S_ESQ_USE: begin
				ex_q   <= prod_q[63:32];
				lcnt_q <= lcnt_q - 5'd1;
			end
			S_PSET: begin
				rem_q  <= '0;
				quo_q  <= '0;
				num_q  <= {pnum, 15'd0};
				den_q  <= 64'(denom);
				dcnt_q <= P_DIV_BITS;
			end
			S_DIV: begin
				// restoring division, one quotient bit per cycle
				if (qbit)
					rem_q <= rem_sh - {1'b0, den_q};
				else
					rem_q <= rem_sh;
				quo_q  <= {quo_q[62:0], qbit};
				num_q  <= {num_q[62:0], 1'b0};
				dcnt_q <= dcnt_q - 7'd1;
			end
			S_DPOST: begin
				case (dop_q)
					DOP_R: r_q <= (quo_q > 64'(R_MAX)) ? R_MAX : quo_q[24:0];
					DOP_F: f_q <= (quo_q > F_SAT_QUO) ? F_FLOOR : (F_ONE - $signed(quo_q[32:0]));
					DOP_T: begin
						term_q <= quo_q[32:0];
						if (ek_q[0])
							sum_q <= sum_q - $signed({3'd0, quo_q[32:0]});
						else
							sum_q <= sum_q + $signed({3'd0, quo_q[32:0]});
						ek_q <= ek_q + 4'd1;
					end
					DOP_P: p_q <= p_new;
					default: ;
				endcase
			end
			S_OUT: begin
				if (out_free) begin
					rsp_bit_q <= {1'b0, draw_q} < p_q;
					rsp_p_q   <= p_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/mgiu_checker.sv */
`include "mrf_gibbs_indicator_update_defines.svh"

module mgiu_sva #(
	parameter int MAX_INDICATORS = mgiu_pkg::MAX_INDICATORS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [mgiu_pkg::KIND_W-1:0]  req_kind,
	input logic [mgiu_pkg::ROW_W-1:0]   req_row_index,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_new_indicator,
	input logic [mgiu_pkg::PROB_W-1:0]  rsp_probability
);
	import mgiu_pkg::*;

	logic upd_transfer;
	assign upd_transfer = req_valid && req_ready && req_kind == KIND_UPDATE
		&& 32'(req_row_index) < MAX_INDICATORS;

	`MGIU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	`MGIU_ASSERT_NEXT(a_busy_after_update, upd_transfer, !req_ready, "request taken during an update")

	`MGIU_ASSERT_NOW(a_result_from_update, $rose(rsp_valid), $past(req_ready) == 1'b0, "result without update")

	`MGIU_ASSERT_NOW(a_prob_range, rsp_valid, (rsp_probability <= 17'd65536) && (!rsp_new_indicator || rsp_probability != 17'd0), "probability and sampled bit disagree")

endmodule

bind mrf_gibbs_indicator_update mgiu_sva #(
	.MAX_INDICATORS(MAX_INDICATORS)
) u_mgiu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_kind         (req.kind),
	.req_row_index    (req.row_index),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_new_indicator(rsp.new_indicator),
	.rsp_probability  (rsp.probability)
);

/* verif/mgiu_checker.sv */
module mgiu_checker
	import mgiu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mgiu_cfg_if  cfg,
	mgiu_in_if   req,
	mgiu_out_if  rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        new_indicator;
		logic [16:0] probability;
	} sample_t;

	sample_t sample_q[$];

	logic signed [31:0] gmat [0:65535];
	logic               sel_bits [0:255];

	longint sparsity;
	longint scale;
	longint slab;
	longint weight;
	longint active;

	initial begin
		fail_count = 0;
		sparsity   = 0;
		scale      = longint'(PRIOR_SCALE_RST);
		slab       = longint'(SLAB_RATIO_RST);
		weight     = longint'($signed(GRAPH_WEIGHT_RST));
		active     = longint'(ACTIVE_COUNT_RST);
		for (int i = 0; i < 256; i++) sel_bits[i] = 1'b0;
		for (int i = 0; i < 65536; i++) gmat[i] = '0;
	end

	assign outstanding = sample_q.size();

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// natural log of a positive q16.16 value
	function automatic longint log_nat(input longint unsigned v);
		int                e;
		longint unsigned   m;
		longint            frac;
		longint            lg;
		e = 0;
		frac = 0;
		while (e < 62 && (v >> (e + 1)) != 0) e++;
		m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
		for (int i = 1; i <= 16; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'sd1 << (16 - i));
			end
		end
		lg = longint'(e - 16) * 65536 + frac;
		return (lg * longint'(LN2_Q16)) >>> 16;
	endfunction

	// exp(-x), x in q16.16 up to 32.0, result q0.32
	function automatic longint unsigned exp_decay(input longint unsigned x);
		longint unsigned t;
		longint unsigned term;
		longint          sum;
		longint unsigned e;
		t = x << 10;
		term = 64'd1 << 32;
		sum = 64'sd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * t) >> 32) / longint'(k);
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > 64'sd4294967295) sum = 64'sd4294967295;
		e = longint'(sum);
		for (int k = 0; k < 6; k++) e = (e * e) >> 32;
		return e;
	endfunction

	function automatic sample_t gibbs_sample(input int row, input logic signed [31:0] beta,
			input logic [15:0] draw);
		sample_t         s;
		longint          n;
		longint unsigned tau;
		longint unsigned cb;
		longint          acc;
		longint          gterm;
		longint          lnterm;
		longint          f;
		longint          qterm;
		longint          lsum;
		longint unsigned babs;
		longint unsigned r;
		longint unsigned h;
		longint unsigned cb2;
		longint unsigned x;
		longint unsigned e;
		longint unsigned denom;
		longint unsigned p;
		n = (active > 256) ? 256 : active;
		tau = (scale == 0) ? 1 : scale;
		cb = (slab == 0) ? 1 : slab;
		acc = longint'(gmat[row * 256 + row]);
		for (int i = 0; i < n; i++)
			if (i != row && sel_bits[i])
				acc = acc + longint'(gmat[i * 256 + row]) + longint'(gmat[row * 256 + i]);
		gterm = clip32((clip32(acc) * weight) >>> 16);
		lnterm = -log_nat(cb);
		babs = (beta < 0) ? longint'(-longint'(beta)) : longint'(beta);
		r = (babs << 16) / tau;
		if (r > (64'd1 << 24)) r = 64'd1 << 24;
		h = (r * r) >> 17;
		cb2 = cb * cb;
		f = 65536 - longint'((64'd1 << 48) / cb2);
		if (f < -(64'sd1 << 31)) f = -(64'sd1 << 31);
		qterm = clip32((longint'(h) * f) >>> 16);
		lsum = sparsity + gterm + lnterm + qterm;
		if (lsum > longint'(L_LIMIT)) lsum = longint'(L_LIMIT);
		if (lsum < -longint'(L_LIMIT)) lsum = -longint'(L_LIMIT);
		x = (lsum < 0) ? longint'(-lsum) : longint'(lsum);
		e = exp_decay(x);
		denom = (64'd1 << 32) + e;
		if (lsum >= 0) p = ((64'd1 << 48) + denom / 2) / denom;
		else p = ((e << 16) + denom / 2) / denom;
		if (p > 65536) p = 65536;
		s.new_indicator = (longint'(draw) < p);
		s.probability = p[16:0];
		sel_bits[row] = s.new_indicator;
		return s;
	endfunction

	always @(posedge clk) begin
		sample_t got;
		sample_t exp_s;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SPARSITY: sparsity = longint'($signed(cfg.data));
					CFG_SCALE:    scale = longint'(cfg.data[30:0]);
					CFG_SLAB:     slab = longint'(cfg.data[30:0]);
					CFG_WEIGHT:   weight = longint'($signed(cfg.data));
					CFG_ACTIVE:   active = longint'(cfg.data[8:0]);
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (req.kind)
					KIND_MATRIX: gmat[req.row_index * 256 + req.col_index] = req.value;
					KIND_BIT:    sel_bits[req.row_index] = req.bit_value;
					KIND_UPDATE: sample_q.push_back(gibbs_sample(int'(req.row_index),
							req.value, req.uniform_draw));
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.new_indicator = rsp.new_indicator;
				got.probability = rsp.probability;
				if (sample_q.size() == 0) begin
					$error("unexpected result: new_indicator %0d probability %0d",
						got.new_indicator, got.probability);
					fail_count++;
				end else begin
					exp_s = sample_q.pop_front();
					if (got.new_indicator !== exp_s.new_indicator) begin
						$error("new_indicator: expected %0d actual %0d",
							exp_s.new_indicator, got.new_indicator);
						fail_count++;
					end
					if (got.probability !== exp_s.probability) begin
						$error("probability: expected %0d actual %0d",
							exp_s.probability, got.probability);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

/* verif/tb_mrf_gibbs_indicator_update.sv */
module tb_mrf_gibbs_indicator_update;
	import mgiu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         LIMIT = 8000000;
	localparam int         PHASES = 8;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycles;
	logic hold_req;
	int   burst_left;

	bit written [0:65535];
	bit maybe_set [0:255];

	mgiu_cfg_if cfg_ch ();
	mgiu_in_if  req_ch ();
	mgiu_out_if rsp_ch ();

	mrf_gibbs_indicator_update i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	mgiu_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("tb_mrf_gibbs_indicator_update failed");
				$finish;
			end
		end
	end

	// result side: changing stall modes plus one long hold-off
	initial begin
		int mode;
		int stretch;
		int hold_left;
		bit held;
		held = 0;
		mode = 0;
		stretch = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				hold_left = 5000;
			end
			if (stretch == 0) begin
				mode = $urandom_range(0, 2);
				stretch = $urandom_range(10, 400);
			end
			stretch--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= $urandom_range(0, 1);
				default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	function automatic logic [31:0] small_q16();
		return 32'($signed($urandom_range(0, 262144)) - 131072);
	endfunction

	function automatic logic [7:0] pool_index();
		int k;
		k = $urandom_range(0, 23);
		return (k < 12) ? 8'(k) : 8'(232 + k);
	endfunction

	task automatic put_item(input logic [1:0] kind, input logic [7:0] row, input logic [7:0] col,
			input logic [31:0] value, input logic bit_v, input logic [15:0] draw);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(50, 300);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.row_index <= row;
		req_ch.col_index <= col;
		req_ch.value <= value;
		req_ch.bit_value <= bit_v;
		req_ch.uniform_draw <= draw;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic load_entry(input logic [7:0] row, input logic [7:0] col,
			input logic [31:0] value);
		put_item(KIND_MATRIX, row, col, value, $urandom_range(0, 1), 16'($urandom));
		written[row * 256 + col] = 1;
	endtask

	task automatic load_bit(input logic [7:0] row, input logic b);
		put_item(KIND_BIT, row, 8'($urandom), $urandom, b, 16'($urandom));
		maybe_set[row] = b;
	endtask

	task automatic ensure_entry(input int row, input int col);
		if (!written[row * 256 + col]) load_entry(8'(row), 8'(col), small_q16());
	endtask

	// every entry the walk can touch must have been loaded first
	task automatic update_bit(input logic [7:0] row, input logic [31:0] beta,
			input logic [15:0] draw);
		ensure_entry(row, row);
		for (int i = 0; i < 256; i++)
			if (maybe_set[i] && i != row) begin
				ensure_entry(i, row);
				ensure_entry(row, i);
			end
		put_item(KIND_UPDATE, row, 8'($urandom), beta, $urandom_range(0, 1), draw);
		maybe_set[row] = 1;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_item();
		int          pick;
		logic [31:0] v;
		pick = $urandom_range(0, 99);
		v = ($urandom_range(0, 9) == 0) ? $urandom : small_q16();
		if (pick < 25) begin
			if ($urandom_range(0, 3) == 0) load_entry(8'($urandom), 8'($urandom), v);
			else load_entry(pool_index(), pool_index(), v);
		end else if (pick < 38) begin
			if ($urandom_range(0, 1) == 0) load_bit(pool_index(), 1'b1);
			else load_bit(($urandom_range(0, 1) == 0) ? pool_index() : 8'($urandom), 1'b0);
		end else if (pick < 41) begin
			put_item(KIND_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom_range(0, 1),
				16'($urandom));
		end else begin
			update_bit(pool_index(), v, 16'($urandom));
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [31:0] sp;
		logic [31:0] sc;
		logic [31:0] sl;
		logic [31:0] wt;
		logic [31:0] ac;
		arst_n = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_SPARSITY;
		cfg_ch.data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_MATRIX;
		req_ch.row_index <= '0;
		req_ch.col_index <= '0;
		req_ch.value <= '0;
		req_ch.bit_value <= 1'b0;
		req_ch.uniform_draw <= '0;
		for (int i = 0; i < 65536; i++) written[i] = 0;
		for (int i = 0; i < 256; i++) maybe_set[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner items under reset settings
		load_entry(8'd0, 8'd0, 32'h7fff_ffff);
		load_entry(8'd255, 8'd255, 32'h8000_0000);
		load_entry(8'd0, 8'd255, 32'h0000_0000);
		load_entry(8'd255, 8'd0, 32'hffff_ffff);
		load_bit(8'd255, 1'b1);
		load_bit(8'd0, 1'b1);
		put_item(KIND_UNUSED, 8'hff, 8'hff, 32'hffff_ffff, 1'b1, 16'hffff);
		update_bit(8'd0, 32'h7fff_ffff, 16'h0000);
		update_bit(8'd255, 32'h8000_0000, 16'hffff);
		update_bit(8'd0, 32'h0000_0000, 16'h8000);
		update_bit(8'd255, 32'h0001_0000, 16'h0000);
		load_bit(8'd0, 1'b0);
		update_bit(8'd255, 32'hffff_0000, 16'hffff);
		load_bit(8'd255, 1'b0);
		update_bit(8'd0, 32'h0000_0001, 16'h7fff);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				sp = 32'($signed($urandom_range(0, 1048576)) - 524288);
				sc = $urandom_range(16384, 262144);
				sl = $urandom_range(65536, 1310720);
				wt = 32'($signed($urandom_range(0, 262144)) - 131072);
				ac = $urandom_range(1, 24);
				case (ph)
					1: begin
						sp = 32'h8000_0000; sc = 32'd1; sl = 32'd0;
						wt = 32'h7fff_ffff; ac = 32'd0;
					end
					2: begin
						sp = 32'h7fff_ffff; sc = 32'h7fff_ffff; sl = 32'd1;
						wt = 32'h8000_0000; ac = 32'd1;
						hold_req = 1'b1;
					end
					3: begin
						sp = 32'd0; sc = 32'd0; sl = 32'h7fff_ffff; ac = 32'd511;
					end
					5: ac = 32'd256;
					default: ;
				endcase
				write_reg(CFG_SPARSITY, sp);
				write_reg(CFG_SCALE, sc);
				write_reg(CFG_SLAB, sl);
				write_reg(CFG_WEIGHT, wt);
				write_reg(CFG_ACTIVE, ac);
			end
			repeat (($urandom_range(0, 3) == 0) ? 120 : 220) random_item();
		end
		settle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_mrf_gibbs_indicator_update passed");
		else
			$display("tb_mrf_gibbs_indicator_update failed");
		$finish;
	end
endmodule
